FILE: sv/esd_pkg.sv
// Shared types, codes and limits of the escape sequence decoder.
package esd_pkg;

    localparam int unsigned MAX_STRING_BYTES = 65536;
    localparam logic [15:0] POS_LIMIT =
        16'((MAX_STRING_BYTES - 1 > 65535) ? 65535 : MAX_STRING_BYTES - 1);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_DROP   = 2'd3;

    localparam logic [1:0] WIDTH_X     = 2'd0;
    localparam logic [1:0] WIDTH_U4    = 2'd1;
    localparam logic [1:0] WIDTH_U8    = 2'd2;

    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_CODEPOINT = 2'd1;
    localparam logic [1:0] KIND_NONE      = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_QUOTE   = 3'd1;
    localparam logic [2:0] ST_NONHEX  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  digits_left;
        logic [31:0] acc;
        logic [1:0]  width_kind;
        logic        err;
        logic [15:0] pos;
    } esd_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] err_pos;
        logic        eos;
    } esd_result_t;

    localparam esd_state_t STATE_RESET = '{
        mode:        MODE_NORMAL,
        digits_left: 4'd0,
        acc:         32'd0,
        width_kind:  WIDTH_X,
        err:         1'b0,
        pos:         16'd0
    };

endpackage

FILE: sv/esd_step.sv
// Per-byte decode: next parser state and the result caused by one byte.
module esd_step
    import esd_pkg::*;
(
    input  esd_state_t  cur,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output esd_state_t  nxt,
    output esd_result_t res
);

    // {valid, decoded byte} for single-letter escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h30:   r = {1'b1, 8'd0};
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h74:   r = {1'b1, 8'd9};
            8'h6E:   r = {1'b1, 8'd10};
            8'h76:   r = {1'b1, 8'd11};
            8'h66:   r = {1'b1, 8'd12};
            8'h72:   r = {1'b1, 8'd13};
            8'h5C:   r = {1'b1, 8'd92};
            8'h27:   r = {1'b1, 8'd39};
            8'h22:   r = {1'b1, 8'd34};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        priority if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else
            r = 5'd0;
        return r;
    endfunction

    logic [8:0]  simple;
    logic [4:0]  hex;
    logic [31:0] acc_shift;
    logic [3:0]  left_dec;
    logic [15:0] pos_inc;
    logic [31:0] byte_ext;

    assign simple    = simple_escape(text_byte);
    assign hex       = hex_value(text_byte);
    assign acc_shift = {cur.acc[27:0], hex[3:0]};
    assign left_dec  = (cur.digits_left == 4'd0) ? 4'd0 : cur.digits_left - 4'd1;
    assign pos_inc   = (cur.pos == 16'hFFFF) ? cur.pos : cur.pos + 16'd1;
    assign byte_ext  = {24'd0, text_byte};

    always_comb
    begin
        nxt = cur;
        res = '0;

        if (cur.mode == MODE_DROP || cur.err)
        begin
            if (last_byte)
            begin
                res.valid = 1'b1;
                res.kind  = KIND_NONE;
                res.eos   = 1'b1;
            end
        end
        else
        begin
            unique case (cur.mode)
                MODE_NORMAL:
                begin
                    if (text_byte == 8'h5C)
                    begin
                        if (last_byte)
                        begin
                            res = '{1'b1, byte_ext, KIND_NONE, ST_TRUNC, pos_inc, 1'b1};
                        end
                        else
                        begin
                            nxt.mode = MODE_ESCAPE;
                        end
                    end
                    else
                    begin
                        res = '{1'b1, byte_ext, KIND_BYTE, ST_OK, 16'd0, last_byte};
                    end
                end
                MODE_ESCAPE:
                begin
                    if (simple[8])
                    begin
                        res = '{1'b1, {24'd0, simple[7:0]}, KIND_BYTE, ST_OK, 16'd0,
                                last_byte};
                        nxt.mode = MODE_NORMAL;
                    end
                    else if (text_byte == 8'h78 || text_byte == 8'h75 || text_byte == 8'h55)
                    begin
                        priority if (text_byte == 8'h78)
                        begin
                            nxt.width_kind  = WIDTH_X;
                            nxt.digits_left = 4'd2;
                        end
                        else if (text_byte == 8'h75)
                        begin
                            nxt.width_kind  = WIDTH_U4;
                            nxt.digits_left = 4'd4;
                        end
                        else
                        begin
                            nxt.width_kind  = WIDTH_U8;
                            nxt.digits_left = 4'd8;
                        end
                        nxt.acc = 32'd0;
                        if (last_byte)
                            res = '{1'b1, byte_ext, KIND_NONE, ST_TRUNC, pos_inc, 1'b1};
                        else
                            nxt.mode = MODE_HEX;
                    end
                    else
                    begin
                        res = '{1'b1, byte_ext, KIND_NONE, ST_UNKNOWN, pos_inc, last_byte};
                        nxt.mode = MODE_DROP;
                        nxt.err  = 1'b1;
                    end
                end
                default:
                begin
                    if (!hex[4])
                    begin
                        res = '{1'b1, byte_ext, KIND_NONE,
                                (text_byte == 8'h22) ? ST_QUOTE : ST_NONHEX,
                                cur.pos, last_byte};
                        nxt.mode = MODE_DROP;
                        nxt.err  = 1'b1;
                    end
                    else
                    begin
                        nxt.acc         = acc_shift;
                        nxt.digits_left = left_dec;
                        if (left_dec == 4'd0)
                        begin
                            if (cur.width_kind == WIDTH_X)
                                res = '{1'b1, {24'd0, acc_shift[7:0]}, KIND_BYTE, ST_OK,
                                        16'd0, last_byte};
                            else
                                res = '{1'b1, acc_shift, KIND_CODEPOINT, ST_OK,
                                        16'd0, last_byte};
                            nxt.mode = MODE_NORMAL;
                        end
                        else if (last_byte)
                        begin
                            res = '{1'b1, byte_ext, KIND_NONE, ST_TRUNC, pos_inc, 1'b1};
                        end
                    end
                end
            endcase
        end

        // end of string returns everything to reset; otherwise advance position
        if (last_byte)
            nxt = STATE_RESET;
        else if (cur.pos < POS_LIMIT)
            nxt.pos = cur.pos + 16'd1;
    end

endmodule

FILE: sv/escape_sequence_decoder.sv
// Each input byte is held in the input register; its result beat is then loaded into the result register.
// Throughput: one byte per cycle unless a result beat waits; the bound is the parser state update.
// Non-last bytes that close no unit (backslash, x/u/U, inner hex digit, dropped) give no beat.
// Backpressure on the result side holds the result register; the input register takes one
// more byte and then the input stalls until the result beat is taken.
// Reset (rst_n low, asynchronous) clears the parser state, the position and both valid flags.
module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] unit_value, [34:32] status,
                                        // [50:35] error_position, [55:51] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] unit_kind
    output logic        m_axis_tlast    // end_of_string
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    esd_state_t  state_reg;
    esd_state_t  state_next;
    esd_result_t res_next;
    esd_result_t out_reg;
    logic        advance;

    assign advance       = in_valid_reg && (!out_reg.valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    esd_step u_step (
        .cur       (state_reg),
        .text_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // hold the result beat until taken; load a new one on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= res_next;
        end
        else if (m_axis_tready)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tdata  = {5'd0, out_reg.err_pos, out_reg.status, out_reg.value};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.eos;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for the escape sequence decoder: directed, random and backpressure runs.
`timescale 1ns / 1ps

module tb_top;
    import esd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESULT_LATENCY = 2;
    localparam int HOLD_CYCLES    = 64;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] SIMPLE_LETTERS [11] =
        '{"0", "a", "b", "t", "n", "f", "v", "r", CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE};
    localparam logic [7:0] HEX_LETTERS [3] = '{"x", "u", "U"};
    localparam int HEX_DIGITS [3] = '{2, 4, 8};

    typedef struct {
        logic [31:0] value;
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] err_pos;
        logic        eos;
    } unit_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] text_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;     // [31:0] unit_value, [34:32] status,
                                   // [50:35] error_position, [55:51] zero
    logic [1:0]  m_axis_tuser;     // [1:0] unit_kind
    logic        m_axis_tlast;

    esd_state_t dec_state = STATE_RESET;
    unit_t      pending_units[$];
    int         fail_count = 0;
    int         bytes_sent = 0;
    bit         src_gaps = 1'b0;
    bit         sink_stalls = 1'b0;
    bit         hold_request = 1'b0;

    escape_sequence_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [3:0] hex_nibble(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic logic [7:0] simple_code(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        case (c)
            "0": return 8'h00;
            "a": return 8'h07;
            "b": return 8'h08;
            "t": return 8'h09;
            "n": return 8'h0A;
            "v": return 8'h0B;
            "f": return 8'h0C;
            "r": return 8'h0D;
            CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: return c;
            default: ok = 1'b0;
        endcase
        return 8'h00;
    endfunction

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + v - 10);
    endfunction

    // Advance the decoder state by one byte and queue the unit it yields, if any.
    task automatic decode_byte(input logic [7:0] c, input logic last);
        unit_t       u;
        logic        emit;
        logic        ok;
        logic [7:0]  code;
        logic [3:0]  nib;
        logic [15:0] pos_next;
        emit = 1'b1;
        u = '{value: 32'(c), kind: KIND_NONE, status: ST_OK, err_pos: 16'd0, eos: last};
        pos_next = (dec_state.pos == 16'hFFFF) ? 16'hFFFF : dec_state.pos + 16'd1;
        if (dec_state.mode == MODE_DROP || dec_state.err)
        begin
            u.value = 32'd0;
            emit = last;
        end
        else if (dec_state.mode == MODE_NORMAL)
        begin
            if (c != CH_BACKSLASH)
                u.kind = KIND_BYTE;
            else if (last)
            begin
                u.status  = ST_TRUNC;
                u.err_pos = pos_next;
            end
            else
            begin
                dec_state.mode = MODE_ESCAPE;
                emit = 1'b0;
            end
        end
        else if (dec_state.mode == MODE_ESCAPE)
        begin
            code = simple_code(c, ok);
            if (ok)
            begin
                u.value = 32'(code);
                u.kind  = KIND_BYTE;
                dec_state.mode = MODE_NORMAL;
            end
            else if (c == "x" || c == "u" || c == "U")
            begin
                dec_state.width_kind  = (c == "x") ? WIDTH_X : (c == "u") ? WIDTH_U4 : WIDTH_U8;
                dec_state.digits_left = (c == "x") ? 4'd2 : (c == "u") ? 4'd4 : 4'd8;
                dec_state.acc = 32'd0;
                if (last)
                begin
                    u.status  = ST_TRUNC;
                    u.err_pos = pos_next;
                end
                else
                begin
                    dec_state.mode = MODE_HEX;
                    emit = 1'b0;
                end
            end
            else
            begin
                // unknown letter: position points just past it
                u.status  = ST_UNKNOWN;
                u.err_pos = pos_next;
                dec_state.mode = MODE_DROP;
                dec_state.err  = 1'b1;
            end
        end
        else
        begin
            nib = hex_nibble(c, ok);
            if (!ok)
            begin
                u.status  = (c == CH_DQUOTE) ? ST_QUOTE : ST_NONHEX;
                u.err_pos = dec_state.pos;
                dec_state.mode = MODE_DROP;
                dec_state.err  = 1'b1;
            end
            else
            begin
                dec_state.acc = {dec_state.acc[27:0], nib};
                if (dec_state.digits_left != 4'd0)
                    dec_state.digits_left = dec_state.digits_left - 4'd1;
                if (dec_state.digits_left == 4'd0)
                begin
                    if (dec_state.width_kind == WIDTH_X)
                    begin
                        u.value = {24'd0, dec_state.acc[7:0]};
                        u.kind  = KIND_BYTE;
                    end
                    else
                    begin
                        u.value = dec_state.acc;
                        u.kind  = KIND_CODEPOINT;
                    end
                    dec_state.mode = MODE_NORMAL;
                end
                else if (last)
                begin
                    u.status  = ST_TRUNC;
                    u.err_pos = pos_next;
                end
                else
                    emit = 1'b0;
            end
        end
        if (emit)
            pending_units.push_back(u);
        if (last)
            dec_state = STATE_RESET;
        else if (dec_state.pos < POS_LIMIT)
            dec_state.pos = dec_state.pos + 16'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t: %s got %0h, want %0h", $time, what, got, want);
    endtask

    // Entered and left at a falling edge; holds valid high into the next beat.
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(c, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
    endtask

    // Mostly well-formed escapes with random content, plus errors, noise and cut-off ends.
    task automatic send_random_string();
        logic [7:0] text[$];
        logic [7:0] c;
        logic       ok;
        int         sel;
        int         w;
        text = {};
        repeat ($urandom_range(1, 12))
        begin
            sel = $urandom_range(0, 99);
            w   = $urandom_range(0, 2);
            if (sel < 38)
            begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_BACKSLASH)
                    c = 8'($urandom_range(0, 255));
                text.push_back(c);
            end
            else if (sel < 55)
            begin
                text.push_back(CH_BACKSLASH);
                text.push_back(SIMPLE_LETTERS[$urandom_range(0, 10)]);
            end
            else if (sel < 80)
            begin
                text.push_back(CH_BACKSLASH);
                text.push_back(HEX_LETTERS[w]);
                repeat (HEX_DIGITS[w]) text.push_back(random_hex_char());
            end
            else if (sel < 86)
            begin
                text.push_back(CH_BACKSLASH);
                text.push_back(HEX_LETTERS[w]);
                repeat ($urandom_range(0, HEX_DIGITS[w] - 1)) text.push_back(random_hex_char());
                if ($urandom_range(0, 2) == 0)
                    text.push_back(CH_DQUOTE);
                else
                begin
                    c = 8'($urandom_range(0, 255));
                    void'(hex_nibble(c, ok));
                    while (ok)
                    begin
                        c = 8'($urandom_range(0, 255));
                        void'(hex_nibble(c, ok));
                    end
                    text.push_back(c);
                end
            end
            else if (sel < 91)
            begin
                text.push_back(CH_BACKSLASH);
                c = 8'($urandom_range(0, 255));
                void'(simple_code(c, ok));
                while (ok || c == "x" || c == "u" || c == "U")
                begin
                    c = 8'($urandom_range(0, 255));
                    void'(simple_code(c, ok));
                end
                text.push_back(c);
            end
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
        // now and then end the string inside an escape
        if ($urandom_range(0, 7) == 0)
        begin
            text.push_back(CH_BACKSLASH);
            sel = $urandom_range(0, 3);
            if (sel > 0)
            begin
                text.push_back(HEX_LETTERS[sel - 1]);
                if ($urandom_range(0, 1) != 0)
                    repeat ($urandom_range(1, HEX_DIGITS[sel - 1] - 1))
                        text.push_back(random_hex_char());
            end
        end
        send_text(text);
    endtask

    task automatic test_directed_units();
        logic [7:0] t[$];
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        t = '{8'h00, 8'hFF, CH_BACKSLASH, "x", "F", "f",
              CH_BACKSLASH, "U", "0", "0", "1", "0", "F", "f", "F", "f"};
        send_text(t);
    endtask

    task automatic test_directed_errors();
        logic [7:0] t[$];
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        // unknown letter, then drop up to the last byte
        t = '{CH_BACKSLASH, "q", "z", "z"};
        send_text(t);
        t = '{CH_BACKSLASH, "x", CH_DQUOTE};
        send_text(t);
        t = '{CH_BACKSLASH, "u", "1", "g", "A"};
        send_text(t);
        // escapes cut short by the end of the string
        t = '{CH_BACKSLASH};
        send_text(t);
        t = '{"A", CH_BACKSLASH, "U"};
        send_text(t);
        t = '{CH_BACKSLASH, "u", "1"};
        send_text(t);
    endtask

    task automatic test_random_strings(input int n_bytes, input bit with_idle);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            src_gaps    = with_idle && ($urandom_range(0, 3) != 0);
            sink_stalls = with_idle && ($urandom_range(0, 3) != 0);
            send_random_string();
        end
    endtask

    // Hold the result side off while bytes keep coming, so the input stalls.
    task automatic test_output_hold();
        logic [7:0] t[$];
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        t = {};
        repeat (40) t.push_back(8'("A" + $urandom_range(0, 25)));
        hold_request = 1'b1;
        send_text(t);
    endtask

    task automatic test_drain_pause();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        repeat (3) send_random_string();
        wait_drained();
        repeat (3) send_random_string();
    endtask

    // Long string: the error position needs more than eight bits.
    task automatic test_long_string();
        logic [7:0] t[$];
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        t = {};
        repeat (280) t.push_back(8'("a" + $urandom_range(0, 25)));
        t.push_back(CH_BACKSLASH);
        t.push_back("x");
        t.push_back("g");
        t.push_back("Z");
        send_text(t);
    endtask

    initial
    begin : sink_ready
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request  = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        unit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_units.size() == 0)
                report_mismatch("result beat with nothing pending", m_axis_tdata[31:0], 32'd0);
            else
            begin
                want = pending_units.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("unit_value", m_axis_tdata[31:0], want.value);
                if (m_axis_tuser !== want.kind)
                    report_mismatch("unit_kind", 32'(m_axis_tuser), 32'(want.kind));
                if (m_axis_tdata[34:32] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[34:32]), 32'(want.status));
                if (m_axis_tdata[50:35] !== want.err_pos)
                    report_mismatch("error_position", 32'(m_axis_tdata[50:35]),
                                    32'(want.err_pos));
                if (m_axis_tlast !== want.eos)
                    report_mismatch("end_of_string", 32'(m_axis_tlast), 32'(want.eos));
                if (m_axis_tdata[55:51] !== 5'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[55:51]), 32'd0);
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("escape_sequence_decoder: mismatch");
        $finish;
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_units();
        test_directed_errors();
        test_random_strings(650, 1'b1);
        test_output_hold();
        test_drain_pause();
        test_random_strings(250, 1'b0);
        test_long_string();

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_units.size() == 0)
            $display("escape_sequence_decoder: match");
        else
            $display("escape_sequence_decoder: mismatch");
        $finish;
    end

endmodule
